/* design/crck_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crck_pkg
// Shared widths, register indexes and CRC-32 fold matrices for the keyed
// CRC-32 word cipher.
// ----------------------------------------------------------------------------
package crck_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned COUNT_W = 3;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [WORD_W-1:0] CRC_POLY_REFLECTED = 32'hEDB8_8320;
   localparam logic [WORD_W-1:0] KEY_MASK_RESET     = 32'h4502_7602;
   localparam logic [WORD_W-1:0] CRC_SEED_RESET     = 32'h0000_0000;
   localparam logic [7:0]        BYTE_MASK          = 8'hFF;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CIPHER_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_SEED    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_MASK    = 2'd2;

   localparam logic CIPHER_ENCRYPT = 1'b0;
   localparam logic CIPHER_DECRYPT = 1'b1;

   // byte counts of a tail transaction
   localparam logic [COUNT_W-1:0] COUNT_NONE  = 3'd0;
   localparam logic [COUNT_W-1:0] COUNT_ONE   = 3'd1;
   localparam logic [COUNT_W-1:0] COUNT_TWO   = 3'd2;
   localparam logic [COUNT_W-1:0] COUNT_THREE = 3'd3;

   typedef logic [WORD_W-1:0] col_array_type [WORD_W];

   // Column i is the register after nbits reflected shifts starting from bit i
   // alone; the whole fold is the XOR of the columns of the set bits.
   function automatic col_array_type fold_columns(int unsigned nbits);
      col_array_type cols;
      logic [WORD_W-1:0] r;
      for (int unsigned i = 0; i < WORD_W; i++) begin
         r = {{(WORD_W-1){1'b0}}, 1'b1} << i;
         for (int unsigned k = 0; k < nbits; k++) begin
            r = (r >> 1) ^ (r[0] ? CRC_POLY_REFLECTED : '0);
         end
         cols[i] = r;
      end
      return cols;
   endfunction

   localparam col_array_type FOLD8_COLS  = fold_columns(8);
   localparam col_array_type FOLD16_COLS = fold_columns(16);
   localparam col_array_type FOLD24_COLS = fold_columns(24);
   localparam col_array_type FOLD32_COLS = fold_columns(32);

   function automatic logic [WORD_W-1:0] apply_fold(col_array_type cols,
                                                    logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] acc;
      acc = '0;
      for (int unsigned i = 0; i < WORD_W; i++) begin
         acc = acc ^ (v[i] ? cols[i] : '0);
      end
      return acc;
   endfunction

endpackage
`default_nettype wire

/* design/crck_channels.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crck channels
// Valid/ready channel interfaces for request and response transactions.
// ----------------------------------------------------------------------------
interface crck_req_if;
   import crck_pkg::*;

   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  data_word;
   logic [COUNT_W-1:0] byte_count;
   logic               first_word;
   logic               last_word;

   modport source (output valid, data_word, byte_count, first_word, last_word,
                   input ready);
   modport sink   (input valid, data_word, byte_count, first_word, last_word,
                   output ready);
endinterface

interface crck_rsp_if;
   import crck_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] out_word;
   logic [WORD_W-1:0] crc_value;
   logic              end_of_buffer;

   modport source (output valid, out_word, crc_value, end_of_buffer,
                   input ready);
   modport sink   (input valid, out_word, crc_value, end_of_buffer,
                   output ready);
endinterface
`default_nettype wire

/* design/crc32_keyed_word_cipher.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crc32_keyed_word_cipher
// Running reflected CRC-32 over little-endian words, with full words ciphered
// by the keystream (CRC register XOR key mask).
// ----------------------------------------------------------------------------
//  channel      direction  content
//  req_channel  in         data_word, byte_count, first_word, last_word
//  rsp_channel  out        out_word, crc_value, end_of_buffer
//  csr_*        in         write enable, index, 32-bit data
//
// One transaction per cycle sustained unless stalled; input register, then
// fold matrix and keystream into the result register. The CRC register is
// updated as the result is loaded, so back-to-back items chain directly.
// Reset is synchronous: CRC register to all ones, configuration to defaults.
// A stalled response holds both stages; input is taken while a stage is free.
// ----------------------------------------------------------------------------
module crc32_keyed_word_cipher (
   input  wire                        clock,
   input  wire                        reset,
   crck_req_if.sink                   req_channel,
   crck_rsp_if.source                 rsp_channel,
   input  wire                        csr_write_enable,
   input  wire [crck_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [crck_pkg::WORD_W-1:0] csr_data
);
   import crck_pkg::*;

   logic              cipher_mode_ff;
   logic [WORD_W-1:0] crc_seed_ff;
   logic [WORD_W-1:0] key_mask_ff;
   logic [WORD_W-1:0] crc_ff, crc_in;

   logic               s1_valid_ff;
   logic [WORD_W-1:0]  s1_word_ff;
   logic [COUNT_W-1:0] s1_count_ff;
   logic               s1_first_ff;
   logic               s1_last_ff;

   logic              rsp_valid_ff;
   logic [WORD_W-1:0] out_word_ff, out_word_in;
   logic [WORD_W-1:0] crc_value_ff;
   logic              eob_ff;

   logic              advance;
   logic              take;
   logic [WORD_W-1:0] crc_start;
   logic [WORD_W-1:0] keystream;
   logic [WORD_W-1:0] plain;
   logic [WORD_W-1:0] tail_word;

   assign advance = !rsp_valid_ff || rsp_channel.ready;
   assign req_channel.ready = !s1_valid_ff || advance;
   assign take = req_channel.valid && req_channel.ready;

   assign rsp_channel.valid         = rsp_valid_ff;
   assign rsp_channel.out_word      = out_word_ff;
   assign rsp_channel.crc_value     = crc_value_ff;
   assign rsp_channel.end_of_buffer = eob_ff;

   always_comb begin
      crc_start = s1_first_ff ? ~crc_seed_ff : crc_ff;
      keystream = crc_start ^ key_mask_ff;
      plain     = (cipher_mode_ff == CIPHER_DECRYPT) ? (s1_word_ff ^ keystream)
                                                     : s1_word_ff;
      tail_word = '0;
      crc_in    = crc_start;
      case (s1_count_ff)
         COUNT_NONE: begin
            tail_word = '0;
            crc_in    = crc_start;
         end
         COUNT_ONE: begin
            tail_word = {24'd0, s1_word_ff[7:0]};
            crc_in    = apply_fold(FOLD8_COLS, crc_start ^ tail_word);
         end
         COUNT_TWO: begin
            tail_word = {16'd0, s1_word_ff[15:0]};
            crc_in    = apply_fold(FOLD16_COLS, crc_start ^ tail_word);
         end
         COUNT_THREE: begin
            tail_word = {8'd0, s1_word_ff[23:0]};
            crc_in    = apply_fold(FOLD24_COLS, crc_start ^ tail_word);
         end
         default: begin
            // four or more counts as a full ciphered word
            tail_word = '0;
            crc_in    = apply_fold(FOLD32_COLS, crc_start ^ plain);
         end
      endcase
      // ciphertext = plaintext ^ keystream in either direction
      out_word_in = s1_count_ff[2] ? (s1_word_ff ^ keystream) : tail_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cipher_mode_ff <= CIPHER_ENCRYPT;
         crc_seed_ff    <= CRC_SEED_RESET;
         key_mask_ff    <= KEY_MASK_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CIPHER_MODE: cipher_mode_ff <= csr_data[0];
            CSR_CRC_SEED:    crc_seed_ff    <= csr_data;
            CSR_KEY_MASK:    key_mask_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         crc_ff       <= {WORD_W{1'b1}};
      end else begin
         if (req_channel.ready) begin
            s1_valid_ff <= take;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
            if (s1_valid_ff) begin
               crc_ff <= crc_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_word_ff  <= req_channel.data_word;
         s1_count_ff <= req_channel.byte_count;
         s1_first_ff <= req_channel.first_word;
         s1_last_ff  <= req_channel.last_word;
      end
      if (advance && s1_valid_ff) begin
         out_word_ff  <= out_word_in;
         crc_value_ff <= ~crc_in;
         eob_ff       <= s1_last_ff;
      end
   end

endmodule
`default_nettype wire
